FILE: hdl/ntmb_pkg.sv
// Shared types and constants for the nearest timestamp match buffer.
// Used by the buffer cells, the top level and the checker; no dependencies.
`default_nettype none

package ntmb_pkg;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned PAY_W  = 16;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned STAT_W = 3;

  localparam logic [CFG_W-1:0] TOLERANCE_RESET = 32'd100000000;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 32'd500000000;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_TIMEOUT   = 1'b1;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_STORED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_EVICTED = 3'd1;
  localparam logic [STAT_W-1:0] ST_MATCHED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STAT_W-1:0] ST_STALE   = 3'd4;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd5;

  // Scan record handed from cell to cell.
  typedef struct packed {
    logic              eq_hit;
    logic              free_hit;
    logic              pick_hit;
    logic              new_hit;
    logic [TIME_W-1:0] pick_stamp;
    logic [TIME_W-1:0] pick_dist;
    logic [PAY_W-1:0]  pick_payload;
    logic [TIME_W-1:0] new_stamp;
  } rec_t;

  // Update command broadcast to all cells.
  typedef struct packed {
    logic              wr;
    logic              kill;
    logic              prune;
    logic [TIME_W-1:0] stamp;
    logic [PAY_W-1:0]  payload;
    logic [TIME_W-1:0] cutoff;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/ntmb_cell.sv
// One buffer entry: holds a stamp, a payload handle and a valid bit.
// Folds its entry into the scan record from its left neighbor. Uses ntmb_pkg.
`default_nettype none

module ntmb_cell import ntmb_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX   = 0
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     op_i,
  input  wire logic [TIME_W-1:0]        ref_i,
  input  wire cmd_t                     cmd_i,
  input  wire logic [$clog2(DEPTH)-1:0] cmd_idx_i,
  input  wire rec_t                     rec_i,
  input  wire logic [$clog2(DEPTH)-1:0] eq_idx_i,
  input  wire logic [$clog2(DEPTH)-1:0] free_idx_i,
  input  wire logic [$clog2(DEPTH)-1:0] pick_idx_i,
  output rec_t                          rec_o,
  output logic [$clog2(DEPTH)-1:0]      eq_idx_o,
  output logic [$clog2(DEPTH)-1:0]      free_idx_o,
  output logic [$clog2(DEPTH)-1:0]      pick_idx_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic              valid_q;
  logic [TIME_W-1:0] stamp_q;
  logic [PAY_W-1:0]  payload_q;
  logic [TIME_W-1:0] dist_q;
  logic [TIME_W-1:0] dist_d;
  logic              sel;

  rec_t          rec_d, rec_q;
  logic [IW-1:0] eq_idx_d, eq_idx_q;
  logic [IW-1:0] free_idx_d, free_idx_q;
  logic [IW-1:0] pick_idx_d, pick_idx_q;

  assign sel    = (cmd_idx_i == MY_IDX);
  assign dist_d = (ref_i >= stamp_q) ? (ref_i - stamp_q) : (stamp_q - ref_i);

  always_comb begin
    rec_d      = rec_i;
    eq_idx_d   = eq_idx_i;
    free_idx_d = free_idx_i;
    pick_idx_d = pick_idx_i;
    if (valid_q) begin
      if (op_i == OP_STORE) begin
        if (!rec_i.eq_hit && stamp_q == ref_i) begin
          rec_d.eq_hit = 1'b1;
          eq_idx_d     = MY_IDX;
        end
        if (!rec_i.pick_hit || stamp_q < rec_i.pick_stamp) begin
          rec_d.pick_hit   = 1'b1;
          rec_d.pick_stamp = stamp_q;
          pick_idx_d       = MY_IDX;
        end
      end else begin
        if (!rec_i.new_hit || stamp_q > rec_i.new_stamp) begin
          rec_d.new_hit   = 1'b1;
          rec_d.new_stamp = stamp_q;
        end
        if (!rec_i.pick_hit || dist_q < rec_i.pick_dist ||
            (dist_q == rec_i.pick_dist && stamp_q < rec_i.pick_stamp)) begin
          rec_d.pick_hit     = 1'b1;
          rec_d.pick_stamp   = stamp_q;
          rec_d.pick_dist    = dist_q;
          rec_d.pick_payload = payload_q;
          pick_idx_d         = MY_IDX;
        end
      end
    end else if (!rec_i.free_hit) begin
      rec_d.free_hit = 1'b1;
      free_idx_d     = MY_IDX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr && sel) begin
        valid_q <= 1'b1;
      end else if (cmd_i.kill && sel) begin
        valid_q <= 1'b0;
      end else if (cmd_i.prune && valid_q && stamp_q <= cmd_i.cutoff) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && sel) begin
      stamp_q   <= cmd_i.stamp;
      payload_q <= cmd_i.payload;
    end
    dist_q     <= dist_d;
    rec_q      <= rec_d;
    eq_idx_q   <= eq_idx_d;
    free_idx_q <= free_idx_d;
    pick_idx_q <= pick_idx_d;
  end

  assign rec_o      = rec_q;
  assign eq_idx_o   = eq_idx_q;
  assign free_idx_o = free_idx_q;
  assign pick_idx_o = pick_idx_q;

endmodule

`default_nettype wire

FILE: hdl/nearest_timestamp_match_buffer_top.sv
// Top level of the nearest timestamp match buffer: control, configuration
// registers, output register and the row of ntmb_cell entries. Uses ntmb_pkg.
//
// Usage:
// Input items arrive on the s_axis channel. tuser carries the operation
// (store or query), tdata the timestamp and payload handle. Each item gives
// exactly one result on the m_axis channel: tuser holds the status, tdata
// the matched payload handle and stamp (zero unless matched).
// Configuration registers (tolerance, timeout) are written through cfg_we_i,
// cfg_addr_i and cfg_wdata_i. The user must write them only while no item is
// in flight; the block itself does not enforce this.
// One item is handled at a time. After a transfer in, the PREP state
// computes the per-entry distances, the SCAN state passes the scan record
// along the row of cells, and the DECIDE state decides and loads the output
// register. The entry update lands in the cycle after the result is loaded,
// together with the earliest next input transfer, so a new item is taken only
// once the previous one has left the DECIDE state.
// When the receiver stalls, the finished result waits in the output
// register; the next item is still taken and worked on, and only its
// decision cycle waits for the output register to free up.
// Reset empties the buffer and loads the default register values.
`default_nettype none

module nearest_timestamp_match_buffer_top import ntmb_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [79:0]       s_axis_tdata_i,  // time_ns[62:0], payload_handle[78:63]
  input  wire logic [0:0]        s_axis_tuser_i,  // operation[0]
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [79:0]            m_axis_tdata_o,  // match_payload[15:0], match_time_ns[78:16]
  output logic [STAT_W-1:0]      m_axis_tuser_o,  // status[2:0]
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_addr_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IW = $clog2(BUFFER_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_PREP   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;

  logic [CFG_W-1:0]  tol_q, timeout_q;
  logic              op_q;
  logic [TIME_W-1:0] ref_q;
  logic [PAY_W-1:0]  pay_q;

  cmd_t          cmd_q, cmd_d;
  logic [IW-1:0] cmd_idx_q, cmd_idx_d;

  logic              out_valid_q;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [PAY_W-1:0]  out_pay_q, out_pay_d;
  logic [TIME_W-1:0] out_time_q, out_time_d;

  rec_t          rec_w      [BUFFER_DEPTH];
  logic [IW-1:0] eq_idx_w   [BUFFER_DEPTH];
  logic [IW-1:0] free_idx_w [BUFFER_DEPTH];
  logic [IW-1:0] pick_idx_w [BUFFER_DEPTH];

  rec_t          fin;
  logic          in_xfer;
  logic          out_free;
  logic          load;
  logic [TIME_W-1:0] span;
  logic          stale;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign load     = (state_q == S_DECIDE) && out_free;
  assign fin      = rec_w[BUFFER_DEPTH-1];
  assign span     = {{(TIME_W-CFG_W-1){1'b0}}, timeout_q, 1'b0};
  assign stale    = (ref_q >= fin.new_stamp) &&
                    ((ref_q - fin.new_stamp) > TIME_W'(timeout_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        state_d = S_SCAN;
        cnt_d   = '0;
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == IW'(BUFFER_DEPTH-1)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_d         = '0;
    cmd_d.stamp   = ref_q;
    cmd_d.payload = pay_q;
    cmd_d.cutoff  = ref_q - span;
    cmd_idx_d     = fin.eq_hit ? eq_idx_w[BUFFER_DEPTH-1] :
                    fin.free_hit ? free_idx_w[BUFFER_DEPTH-1] :
                    pick_idx_w[BUFFER_DEPTH-1];
    out_status_d  = ST_STORED;
    out_pay_d     = '0;
    out_time_d    = '0;
    if (op_q == OP_STORE) begin
      cmd_d.wr = 1'b1;
      if (!fin.eq_hit && !fin.free_hit) begin
        out_status_d = ST_EVICTED;
      end
    end else begin
      cmd_idx_d   = pick_idx_w[BUFFER_DEPTH-1];
      cmd_d.prune = (ref_q >= span);
      if (!fin.new_hit) begin
        out_status_d = ST_EMPTY;
      end else if (stale) begin
        out_status_d = ST_STALE;
      end else if (fin.pick_dist <= TIME_W'(tol_q)) begin
        out_status_d = ST_MATCHED;
        out_pay_d    = fin.pick_payload;
        out_time_d   = fin.pick_stamp;
        cmd_d.kill   = 1'b1;
      end else begin
        out_status_d = ST_OUTSIDE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tol_q       <= TOLERANCE_RESET;
      timeout_q   <= TIMEOUT_RESET;
      cmd_q       <= '0;
      cmd_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_TOLERANCE) begin
          tol_q <= cfg_wdata_i;
        end else begin
          timeout_q <= cfg_wdata_i;
        end
      end
      if (load) begin
        cmd_q     <= cmd_d;
        cmd_idx_q <= cmd_idx_d;
      end else begin
        cmd_q <= '0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= s_axis_tuser_i[0];
      ref_q <= s_axis_tdata_i[62:0];
      pay_q <= s_axis_tdata_i[78:63];
    end
    if (load) begin
      out_status_q <= out_status_d;
      out_pay_q    <= out_pay_d;
      out_time_q   <= out_time_d;
    end
  end

  for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
    rec_t          rec_in;
    logic [IW-1:0] eq_in, free_in, pick_in;
    if (i == 0) begin : g_head
      assign rec_in  = '0;
      assign eq_in   = '0;
      assign free_in = '0;
      assign pick_in = '0;
    end else begin : g_link
      assign rec_in  = rec_w[i-1];
      assign eq_in   = eq_idx_w[i-1];
      assign free_in = free_idx_w[i-1];
      assign pick_in = pick_idx_w[i-1];
    end
    ntmb_cell #(
      .DEPTH (BUFFER_DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (op_q),
      .ref_i      (ref_q),
      .cmd_i      (cmd_q),
      .cmd_idx_i  (cmd_idx_q),
      .rec_i      (rec_in),
      .eq_idx_i   (eq_in),
      .free_idx_i (free_in),
      .pick_idx_i (pick_in),
      .rec_o      (rec_w[i]),
      .eq_idx_o   (eq_idx_w[i]),
      .free_idx_o (free_idx_w[i]),
      .pick_idx_o (pick_idx_w[i])
    );
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_time_q, out_pay_q};

endmodule

`default_nettype wire

FILE: hdl/ntmb_checker.sv
// Port-level checker for the nearest timestamp match buffer and its bind
// to the top level. Uses ntmb_pkg.
`default_nettype none

module ntmb_checker import ntmb_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [79:0]       m_axis_tdata_o,
  input wire logic [STAT_W-1:0] m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result transfer dropped while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("new item taken while one is in flight");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= ST_OUTSIDE)
    else $error("unknown status code");

  a_zero_unless_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_MATCHED |-> m_axis_tdata_o == '0)
    else $error("match fields set without a match");

endmodule

bind nearest_timestamp_match_buffer_top ntmb_checker u_ntmb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
